// ===== design/ils_pkg.sv =====
// Package for the indexed list store: sizes, action and status codes,
// and the request, response and cell command types.
// Has no dependencies; every other design file uses it.
package ils_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = 7;
  localparam int POS_W    = 7;
  localparam int ACT_W    = 3;
  localparam int ST_W     = 2;
  localparam int DATA_W   = 32;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(DEPTH);

  localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_HEAD   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TAIL   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         count_after;
  } rsp_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== design/ils_cell.sv =====
// One storage cell of the list: holds a single value and, on a command,
// takes its left neighbor, its right neighbor or the new value.
// Depends on ils_pkg.
module ils_cell (
  input  logic                       clk,
  input  logic [ils_pkg::IDX_W-1:0]  idx,
  input  ils_pkg::cell_cmd_t         cmd,
  input  logic [ils_pkg::DATA_W-1:0] left,
  input  logic [ils_pkg::DATA_W-1:0] right,
  output logic [ils_pkg::DATA_W-1:0] value
);

  logic [ils_pkg::POS_W-1:0]  here;
  logic [ils_pkg::DATA_W-1:0] value_next;

  assign here = ils_pkg::POS_W'(idx);

  always_comb begin
    value_next = value;
    if (cmd.ins) begin
      if (here > cmd.pos) begin
        value_next = left;
      end else if (here == cmd.pos) begin
        value_next = cmd.value;
      end
    end else if (cmd.del) begin
      if (here >= cmd.pos) begin
        value_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== design/ils_chain.sv =====
// Row of list cells linked to their neighbors, with the read select
// that picks the value at a position.
// Depends on ils_pkg and ils_cell.
module ils_chain (
  input  logic                       clk,
  input  ils_pkg::cell_cmd_t         cmd,
  input  logic [ils_pkg::IDX_W-1:0]  rd_idx,
  output logic [ils_pkg::DATA_W-1:0] rd_data
);

  logic [ils_pkg::DEPTH-1:0][ils_pkg::DATA_W-1:0] cells;

  for (genvar i = 0; i < ils_pkg::DEPTH; i++) begin : g_cell
    logic [ils_pkg::DATA_W-1:0] left;
    logic [ils_pkg::DATA_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = cells[i];
    end else begin : g_mid_l
      assign left = cells[i-1];
    end
    if (i == ils_pkg::DEPTH - 1) begin : g_last
      assign right = cells[i];
    end else begin : g_mid_r
      assign right = cells[i+1];
    end

    ils_cell u_cell (
      .clk   (clk),
      .idx   (ils_pkg::IDX_W'(i)),
      .cmd   (cmd),
      .left  (left),
      .right (right),
      .value (cells[i])
    );
  end

  assign rd_data = cells[rd_idx];

endmodule

// ===== design/indexed_list_store.sv =====
// Indexed list store: an ordered list of up to 64 signed 32-bit values.
// Each request beat carries an action, a position and a value. Actions:
// read at position, insert at head, append at tail, insert before position
// and delete at position. Inserting at a position equal to the count appends.
// Every request beat yields exactly one response beat with the read value,
// a status (done, out of range, full) and the count after the step.
// The list lives in a row of 64 cells; an insert shifts every cell at or
// past the position one place right, a delete shifts them one place left,
// both at the edge that takes the request, so one request is taken per cycle
// while req_stall is low. The response is registered at the edge that takes
// the request. A new request is taken while the response register is empty
// or being drained in the same cycle.
// When the receiver stalls, the response holds and req_stall rises, so at
// most one response waits. Reset empties the list and the response register;
// cell contents are left as they are and are never read before being written.
// Depends on ils_pkg and ils_chain.
module indexed_list_store (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ils_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ils_pkg::rsp_t rsp
);

  logic [ils_pkg::CNT_W-1:0]  count;
  logic [ils_pkg::CNT_W-1:0]  count_next;
  logic                       take;
  logic                       full;
  logic                       rd_ok;
  logic [ils_pkg::DATA_W-1:0] rd_data;
  ils_pkg::cell_cmd_t         cmd;
  ils_pkg::rsp_t              rsp_next;

  assign req_stall = rsp_valid & rsp_stall;
  assign take      = req_valid & ~req_stall;
  assign full      = (count == ils_pkg::CAP_CNT);
  assign rd_ok     = (req.position < count);

  ils_chain u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .rd_idx  (req.position[ils_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    cmd.ins   = 1'b0;
    cmd.del   = 1'b0;
    cmd.pos   = req.position;
    cmd.value = req.item_value;
    rsp_next.read_value = '0;
    rsp_next.status     = ils_pkg::ST_DONE;
    count_next          = count;
    case (req.action)
      ils_pkg::ACT_READ: begin
        if (rd_ok) begin
          rsp_next.read_value = rd_data;
        end else begin
          rsp_next.read_value = '1;
          rsp_next.status     = ils_pkg::ST_RANGE;
        end
      end
      ils_pkg::ACT_HEAD: begin
        cmd.pos = '0;
        if (full) begin
          rsp_next.status = ils_pkg::ST_FULL;
        end else begin
          cmd.ins    = 1'b1;
          count_next = count + ils_pkg::CNT_W'(1);
        end
      end
      ils_pkg::ACT_TAIL: begin
        cmd.pos = count;
        if (full) begin
          rsp_next.status = ils_pkg::ST_FULL;
        end else begin
          cmd.ins    = 1'b1;
          count_next = count + ils_pkg::CNT_W'(1);
        end
      end
      ils_pkg::ACT_INSERT: begin
        if (req.position > count) begin
          rsp_next.status = ils_pkg::ST_RANGE;
        end else if (full) begin
          rsp_next.status = ils_pkg::ST_FULL;
        end else begin
          cmd.ins    = 1'b1;
          count_next = count + ils_pkg::CNT_W'(1);
        end
      end
      ils_pkg::ACT_DELETE: begin
        if (rd_ok) begin
          cmd.del    = 1'b1;
          count_next = count - ils_pkg::CNT_W'(1);
        end else begin
          rsp_next.status = ils_pkg::ST_RANGE;
        end
      end
      default: begin
        rsp_next.status = ils_pkg::ST_RANGE;
      end
    endcase
    rsp_next.count_after = count_next;
    if (!take) begin
      cmd.ins = 1'b0;
      cmd.del = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== tb/indexed_list_store_tb.sv =====
`timescale 1ns / 100ps
// Testbench for indexed_list_store: a directed table, then random beats
// under several idle and stall mixes; each response is checked against a
// testbench list model or table value. Depends on ils_pkg and the design.
module indexed_list_store_tb;
  import ils_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  localparam int MIX_FILL  = 0;
  localparam int MIX_BLEND = 1;
  localparam int MIX_DRAIN = 2;

  localparam int LONG_HOLD = 50;
  localparam int SEG_BEATS = 100;

  typedef struct {
    req_t beat;
    int   reps;
    bit   fixed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic signed [DATA_W-1:0] list_mem [DEPTH];
  int   list_cnt = 0;
  rsp_t expected_q [$];
  int   mismatches = 0;

  logic cur_fixed = 1'b0;
  rsp_t cur_want  = '0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_requests  = 0;
  int   hold_served    = 0;
  int   hold_left      = 0;

  indexed_list_store dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic rsp_t apply_action(input req_t r);
    rsp_t o;
    int   p;
    o = '0;
    o.status = ST_DONE;
    p = r.position;
    case (r.action)
      ACT_READ: begin
        if (p < list_cnt) begin
          o.read_value = list_mem[p];
        end else begin
          o.read_value = 32'hffff_ffff;
          o.status = ST_RANGE;
        end
      end
      ACT_HEAD, ACT_TAIL, ACT_INSERT: begin
        if (r.action == ACT_HEAD) p = 0;
        else if (r.action == ACT_TAIL) p = list_cnt;
        if (p > list_cnt) begin
          o.status = ST_RANGE;
        end else if (list_cnt >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (int i = list_cnt; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = r.item_value;
          list_cnt++;
        end
      end
      ACT_DELETE: begin
        if (p < list_cnt) begin
          for (int i = p; i < list_cnt - 1; i++) list_mem[i] = list_mem[i+1];
          list_cnt--;
        end else begin
          o.status = ST_RANGE;
        end
      end
      default: o.status = ST_RANGE;
    endcase
    o.count_after = CNT_W'(list_cnt);
    return o;
  endfunction

  function automatic req_t make_beat(input int mix);
    req_t b;
    int   pick;
    b.item_value = $urandom;
    if ($urandom_range(15) == 0) begin
      case ($urandom_range(3))
        0:       b.item_value = 32'h7fff_ffff;
        1:       b.item_value = 32'h8000_0000;
        2:       b.item_value = 32'h0000_0000;
        default: b.item_value = 32'hffff_ffff;
      endcase
    end
    b.position = POS_W'($urandom_range(127));
    if ($urandom_range(99) < 5) begin
      b.action = ACT_W'($urandom_range(7));
    end else begin
      pick = $urandom_range(99);
      if (mix == MIX_FILL) begin
        if (pick < 10) b.action = ACT_READ;
        else if (pick < 30) b.action = ACT_HEAD;
        else if (pick < 50) b.action = ACT_TAIL;
        else if (pick < 90) b.action = ACT_INSERT;
        else b.action = ACT_DELETE;
      end else if (mix == MIX_DRAIN) begin
        if (pick < 10) b.action = ACT_READ;
        else if (pick < 15) b.action = ACT_HEAD;
        else if (pick < 20) b.action = ACT_TAIL;
        else if (pick < 25) b.action = ACT_INSERT;
        else b.action = ACT_DELETE;
      end else begin
        if (pick < 20) b.action = ACT_READ;
        else if (pick < 40) b.action = ACT_HEAD;
        else if (pick < 60) b.action = ACT_TAIL;
        else if (pick < 80) b.action = ACT_INSERT;
        else b.action = ACT_DELETE;
      end
      if ((b.action == ACT_READ || b.action == ACT_DELETE) && list_cnt > 0 &&
          $urandom_range(9) != 0)
        b.position = POS_W'($urandom_range(list_cnt - 1));
      if (b.action == ACT_INSERT && $urandom_range(9) != 0)
        b.position = POS_W'($urandom_range(list_cnt));
    end
    return b;
  endfunction

  function automatic dir_row_t pred_row(input logic [ACT_W-1:0] a,
                                        input logic [POS_W-1:0] p,
                                        input logic [DATA_W-1:0] v, input int reps);
    dir_row_t d;
    d.beat  = '{action: a, position: p, item_value: v};
    d.reps  = reps;
    d.fixed = 1'b0;
    d.want  = '0;
    return d;
  endfunction

  function automatic dir_row_t fixed_row(input logic [ACT_W-1:0] a,
                                         input logic [POS_W-1:0] p,
                                         input logic [DATA_W-1:0] v,
                                         input logic [DATA_W-1:0] rv,
                                         input logic [ST_W-1:0] st,
                                         input logic [CNT_W-1:0] c);
    dir_row_t d;
    d.beat  = '{action: a, position: p, item_value: v};
    d.reps  = 1;
    d.fixed = 1'b1;
    d.want  = '{read_value: rv, status: st, count_after: c};
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic send_beat(input req_t b, input logic fixed, input rsp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= b;
    req_valid <= 1'b1;
    cur_fixed  = fixed;
    cur_want   = want;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : check_p
    rsp_t want_beat;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("beat with nothing expected", rsp.read_value, '0);
        end else begin
          want_beat = expected_q.pop_front();
          if (rsp.read_value !== want_beat.read_value)
            report_mismatch("read_value", rsp.read_value, want_beat.read_value);
          if (rsp.status !== want_beat.status)
            report_mismatch("status", DATA_W'(rsp.status), DATA_W'(want_beat.status));
          if (rsp.count_after !== want_beat.count_after)
            report_mismatch("count_after", DATA_W'(rsp.count_after),
                            DATA_W'(want_beat.count_after));
        end
      end
      if (req_valid && !req_stall) begin
        want_beat = apply_action(req);
        expected_q.push_back(cur_fixed ? cur_want : want_beat);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    dir_row_t directed [$];
    req_t     b;
    directed = '{
      fixed_row(ACT_READ,   0,   32'h0,         32'hffff_ffff, ST_RANGE, 0),
      fixed_row(ACT_DELETE, 0,   32'h0,         32'h0,         ST_RANGE, 0),
      fixed_row(ACT_INSERT, 1,   32'h1234,      32'h0,         ST_RANGE, 0),
      pred_row (ACT_INSERT, 0,   32'h7fff_ffff, 1),
      pred_row (ACT_HEAD,   0,   32'h8000_0000, 1),
      pred_row (ACT_TAIL,   127, 32'h0,         1),
      pred_row (ACT_TAIL,   0,   32'hffff_ffff, 1),
      pred_row (ACT_INSERT, 4,   32'h5,         1),
      pred_row (ACT_READ,   0,   32'h0,         5),
      fixed_row(ACT_READ,   127, 32'h0,         32'hffff_ffff, ST_RANGE, 5),
      fixed_row(ACT_SPARE5, 0,   32'hffff_ffff, 32'h0,         ST_RANGE, 5),
      fixed_row(ACT_SPARE6, 127, 32'h0,         32'h0,         ST_RANGE, 5),
      fixed_row(ACT_SPARE7, 3,   32'h1,         32'h0,         ST_RANGE, 5),
      pred_row (ACT_DELETE, 2,   32'h0,         1),
      fixed_row(ACT_DELETE, 127, 32'h0,         32'h0,         ST_RANGE, 4),
      pred_row (ACT_TAIL,   0,   32'h100,       60),
      fixed_row(ACT_TAIL,   0,   32'h1,         32'h0,         ST_FULL,  64),
      fixed_row(ACT_HEAD,   0,   32'h1,         32'h0,         ST_FULL,  64),
      fixed_row(ACT_INSERT, 64,  32'h1,         32'h0,         ST_FULL,  64),
      fixed_row(ACT_INSERT, 65,  32'h1,         32'h0,         ST_RANGE, 64),
      fixed_row(ACT_INSERT, 127, 32'h1,         32'h0,         ST_RANGE, 64),
      pred_row (ACT_READ,   63,  32'h0,         1),
      fixed_row(ACT_READ,   64,  32'h0,         32'hffff_ffff, ST_RANGE, 64),
      pred_row (ACT_DELETE, 63,  32'h0,         1),
      pred_row (ACT_DELETE, 0,   32'h0,         1),
      pred_row (ACT_INSERT, 62,  32'hdead_beef, 1),
      pred_row (ACT_READ,   0,   32'h0,         1)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      for (int k = 0; k < directed[i].reps; k++) begin
        b = directed[i].beat;
        b.position   = b.position + POS_W'(k);
        b.item_value = b.item_value + k;
        send_beat(b, directed[i].fixed, directed[i].want);
      end
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int seg = MIX_FILL; seg <= MIX_DRAIN; seg++) begin
        if (seg == MIX_FILL) hold_requests++;
        for (int n = 0; n < SEG_BEATS; n++) send_beat(make_beat(seg), 1'b0, '0);
      end
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
